[sv/tts_pkg.sv]
// ----------------------------------------------------------------------------
// tts_pkg
// shared types, widths and fixed-point helpers of the tridiagonal solver
// ----------------------------------------------------------------------------
`default_nettype none

package tts_pkg;

  localparam int DATA_W = 32;
  localparam int ROW_W  = 6;
  localparam int NORM_W = 31;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic signed [2*DATA_W-1:0] wide_t;

  typedef struct packed {
    logic  start;
    data_t num;
    data_t den;
  } div_req_t;

  typedef struct packed {
    logic  done;
    data_t quot;
    logic  sat;
  } div_rsp_t;

  localparam wide_t POS_MAX = wide_t'(64'sh0000_0000_7FFF_FFFF);
  localparam wide_t NEG_MIN = wide_t'(-64'sh0000_0000_8000_0000);

  function automatic wide_t sx64(input data_t x);
    return wide_t'(x);
  endfunction

  function automatic data_t sat32(input wide_t v);
    data_t r;
    if (v > POS_MAX) begin
      r = data_t'(POS_MAX);
    end else if (v < NEG_MIN) begin
      r = data_t'(NEG_MIN);
    end else begin
      r = data_t'(v);
    end
    return r;
  endfunction

  function automatic logic clip32(input wide_t v);
    return (v > POS_MAX) || (v < NEG_MIN);
  endfunction

  // zero pivot becomes one lsb
  function automatic data_t nz(input data_t x);
    return (x == '0) ? data_t'(1) : x;
  endfunction

endpackage

`default_nettype wire

[sv/tts_if.sv]
// ----------------------------------------------------------------------------
// tts channel interfaces
// row request channel and solution result channel
// ----------------------------------------------------------------------------
`default_nettype none

interface tts_in_if;
  import tts_pkg::*;
  logic  valid;
  logic  ready;
  data_t sub_diag;
  data_t main_diag;
  data_t super_diag;
  data_t right_side;
  logic  final_row;
  modport source (output valid, sub_diag, main_diag, super_diag, right_side, final_row,
                  input ready);
  modport sink (input valid, sub_diag, main_diag, super_diag, right_side, final_row,
                output ready);
endinterface

interface tts_out_if;
  import tts_pkg::*;
  logic              valid;
  logic              ready;
  data_t             solution;
  logic [ROW_W-1:0]  row_index;
  logic              last_result;
  logic [NORM_W-1:0] residual_norm;
  logic              overflow_flag;
  modport source (output valid, solution, row_index, last_result, residual_norm,
                  overflow_flag, input ready);
  modport sink (input valid, solution, row_index, last_result, residual_norm,
                overflow_flag, output ready);
endinterface

`default_nettype wire

[sv/tridiagonal_thomas_solver_core.sv]
// ----------------------------------------------------------------------------
// tridiagonal_thomas_solver_core
// fixed-point thomas solver with residual norm, rows held in block memories
// ----------------------------------------------------------------------------
//  channel  | dir | handshake     | payload
//  in_ch    | in  | valid/ready   | sub_diag, main_diag, super_diag, right_side, final_row
//  out_ch   | out | valid/ready   | solution, row_index, last_result, residual_norm,
//           |     |               | overflow_flag
//
//  a row request is accepted whenever the core is idle; a final one starts the solve
//  the forward sweep runs the divider twice per row (once on the final row),
//  then come back substitution, the residual and the square root
//  results leave one at a time, each held until taken; input is held off meanwhile
//  synchronous active-low reset clears control state only; the memories are not cleared
// ----------------------------------------------------------------------------
`default_nettype none

module tridiagonal_thomas_solver_core #(
  parameter int MAX_ROWS  = 64,
  parameter int FRAC_BITS = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  tts_in_if.sink   in_ch,
  tts_out_if.source out_ch
);
  import tts_pkg::*;

  localparam int AW = $clog2(MAX_ROWS);
  localparam int CW = $clog2(MAX_ROWS + 1);

  typedef enum logic [4:0] {
    S_IDLE, F_RD, F_MA, F_MB, F_MC, F_DC, F_WC, F_DD, F_WD,
    B_RD, B_MUL, B_SUB, R_RD, R_M0, R_M1, R_M2, R_M3, R_SQ, R_AC,
    Q_RUN, E_RD, E_LD, E_WT
  } state_t;

  state_t state_r;

  logic [4*DATA_W-1:0] coef_mem [MAX_ROWS];
  logic [2*DATA_W-1:0] sw_mem   [MAX_ROWS];
  logic [4*DATA_W-1:0] coef_rd_r;
  logic [2*DATA_W-1:0] sw_rd_r;

  logic                coef_we, coef_re, sw_we, sw_re;
  logic [AW-1:0]       coef_wa, coef_ra, sw_wa, sw_ra;
  logic [4*DATA_W-1:0] coef_wd;
  logic [2*DATA_W-1:0] sw_wd;

  logic [CW-1:0]   cnt_r, n_r;
  logic            sticky_r, ov_r;
  logic [AW-1:0]   idx_r;
  data_t           den_r, num_r, cp_r, dp_r, x_r, xm_r, xc_r, xp_r;
  wide_t           prod_r, acc_r;
  logic [DATA_W-1:0] mag_r;
  logic [63:0]     sq_r, sum_r, res_r, bit_r;

  logic              out_valid_r;
  data_t             out_sol_r;
  logic [ROW_W-1:0]  out_row_r;
  logic              out_last_r;
  logic [NORM_W-1:0] out_norm_r;
  logic              out_ov_r;

  data_t    mul_a, mul_b;
  div_req_t div_req;
  div_rsp_t div_rsp;

  logic     in_acc, room, last_row;
  data_t    co_a, co_b, co_c, co_d, sw_cp, sw_x, x_v;
  wide_t    prod_sh, r_v, r_abs;
  wide_t    den_v, num_v, xw_v;
  logic [64:0] sum_add;
  logic [63:0] sum_nxt, trial;

  tts_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign room        = cnt_r < CW'(MAX_ROWS);
  assign last_row    = (CW'(idx_r) + CW'(1)) == n_r;

  assign co_a  = data_t'(coef_rd_r[4*DATA_W-1:3*DATA_W]);
  assign co_b  = data_t'(coef_rd_r[3*DATA_W-1:2*DATA_W]);
  assign co_c  = data_t'(coef_rd_r[2*DATA_W-1:DATA_W]);
  assign co_d  = data_t'(coef_rd_r[DATA_W-1:0]);
  assign sw_cp = data_t'(sw_rd_r[2*DATA_W-1:DATA_W]);
  assign sw_x  = data_t'(sw_rd_r[DATA_W-1:0]);

  assign prod_sh = prod_r >>> FRAC_BITS;
  assign den_v   = sx64(co_b) - prod_sh;
  assign num_v   = sx64(co_d) - prod_sh;
  assign xw_v    = sx64(sw_x) - prod_sh;
  assign x_v     = sat32(xw_v);
  assign r_v     = acc_r - prod_sh;
  assign r_abs   = r_v[63] ? -r_v : r_v;
  assign sum_add = {1'b0, sum_r} + {1'b0, sq_r};
  assign sum_nxt = sum_add[64] ? '1 : sum_add[63:0];
  assign trial   = res_r + bit_r;

  always_comb begin
    coef_we = in_acc && room;
    coef_wa = cnt_r[AW-1:0];
    coef_wd = {in_ch.sub_diag, in_ch.main_diag, in_ch.super_diag, in_ch.right_side};
    coef_re = (state_r == F_RD) || (state_r == R_RD);
    coef_ra = idx_r;
    sw_we   = 1'b0;
    sw_wa   = idx_r;
    sw_wd   = {cp_r, div_rsp.quot};
    sw_re   = (state_r == B_RD) || (state_r == R_RD) || (state_r == E_RD);
    sw_ra   = (state_r == R_RD) ? AW'(idx_r + AW'(1)) : idx_r;
    mul_a   = '0;
    mul_b   = '0;
    div_req = '0;
    case (state_r)
      F_MA: begin
        mul_a = co_a;
        mul_b = cp_r;
      end
      F_MB: begin
        mul_a = co_a;
        mul_b = dp_r;
      end
      F_DC: begin
        div_req.start = !last_row;
        div_req.num   = co_c;
        div_req.den   = den_r;
      end
      F_DD: begin
        div_req.start = 1'b1;
        div_req.num   = num_r;
        div_req.den   = den_r;
      end
      F_WD: begin
        sw_we = div_rsp.done;
      end
      B_MUL: begin
        mul_a = sw_cp;
        mul_b = x_r;
      end
      B_SUB: begin
        sw_we = 1'b1;
        sw_wd = {sw_cp, x_v};
      end
      R_M0: begin
        mul_a = co_b;
        mul_b = xc_r;
      end
      R_M1: begin
        mul_a = co_a;
        mul_b = xm_r;
      end
      R_M2: begin
        mul_a = co_c;
        mul_b = xp_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (coef_we) begin
      coef_mem[coef_wa] <= coef_wd;
    end
    if (coef_re) begin
      coef_rd_r <= coef_mem[coef_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (sw_we) begin
      sw_mem[sw_wa] <= sw_wd;
    end
    if (sw_re) begin
      sw_rd_r <= sw_mem[sw_ra];
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= wide_t'(mul_a * mul_b);
    sq_r   <= 64'(mag_r * mag_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      sticky_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (in_ch.final_row) begin
              n_r      <= room ? cnt_r + CW'(1) : cnt_r;
              ov_r     <= sticky_r | !room;
              cnt_r    <= '0;
              sticky_r <= 1'b0;
              idx_r    <= '0;
              state_r  <= F_RD;
            end else begin
              if (room) begin
                cnt_r <= cnt_r + CW'(1);
              end else begin
                sticky_r <= 1'b1;
              end
            end
          end
        end
        F_RD: state_r <= F_MA;
        F_MA: begin
          if (idx_r == '0) begin
            den_r   <= nz(co_b);
            num_r   <= co_d;
            state_r <= F_DC;
          end else begin
            state_r <= F_MB;
          end
        end
        F_MB: begin
          den_r   <= nz(sat32(den_v));
          ov_r    <= ov_r | clip32(den_v);
          state_r <= F_MC;
        end
        F_MC: begin
          num_r   <= sat32(num_v);
          ov_r    <= ov_r | clip32(num_v);
          state_r <= F_DC;
        end
        F_DC: begin
          if (last_row) begin
            cp_r    <= '0;
            state_r <= F_DD;
          end else begin
            state_r <= F_WC;
          end
        end
        F_WC: begin
          if (div_rsp.done) begin
            cp_r    <= div_rsp.quot;
            ov_r    <= ov_r | div_rsp.sat;
            state_r <= F_DD;
          end
        end
        F_DD: state_r <= F_WD;
        F_WD: begin
          if (div_rsp.done) begin
            dp_r <= div_rsp.quot;
            ov_r <= ov_r | div_rsp.sat;
            if (last_row) begin
              x_r <= div_rsp.quot;
              if (n_r == CW'(1)) begin
                idx_r   <= '0;
                xm_r    <= '0;
                xc_r    <= div_rsp.quot;
                sum_r   <= '0;
                state_r <= R_RD;
              end else begin
                idx_r   <= AW'(n_r - CW'(2));
                state_r <= B_RD;
              end
            end else begin
              idx_r   <= idx_r + AW'(1);
              state_r <= F_RD;
            end
          end
        end
        B_RD:  state_r <= B_MUL;
        B_MUL: state_r <= B_SUB;
        B_SUB: begin
          x_r  <= x_v;
          ov_r <= ov_r | clip32(xw_v);
          if (idx_r == '0) begin
            xm_r    <= '0;
            xc_r    <= x_v;
            sum_r   <= '0;
            state_r <= R_RD;
          end else begin
            idx_r   <= idx_r - AW'(1);
            state_r <= B_RD;
          end
        end
        R_RD: state_r <= R_M0;
        R_M0: begin
          acc_r   <= sx64(co_d);
          xp_r    <= last_row ? data_t'(0) : sw_x;
          state_r <= R_M1;
        end
        R_M1: begin
          acc_r   <= acc_r - prod_sh;
          state_r <= R_M2;
        end
        R_M2: begin
          acc_r   <= acc_r - prod_sh;
          state_r <= R_M3;
        end
        R_M3: begin
          mag_r   <= (r_abs[63:DATA_W] != '0) ? '1 : r_abs[DATA_W-1:0];
          state_r <= R_SQ;
        end
        R_SQ: state_r <= R_AC;
        R_AC: begin
          sum_r <= sum_nxt;
          xm_r  <= xc_r;
          xc_r  <= xp_r;
          if (last_row) begin
            res_r   <= '0;
            bit_r   <= 64'h4000_0000_0000_0000;
            state_r <= Q_RUN;
          end else begin
            idx_r   <= idx_r + AW'(1);
            state_r <= R_RD;
          end
        end
        Q_RUN: begin
          if (bit_r != '0) begin
            if (sum_r >= trial) begin
              sum_r <= sum_r - trial;
              res_r <= (res_r >> 1) + bit_r;
            end else begin
              res_r <= res_r >> 1;
            end
            bit_r <= bit_r >> 2;
          end else begin
            if (res_r[63:NORM_W] != '0) begin
              ov_r       <= 1'b1;
              out_norm_r <= '1;
            end else begin
              out_norm_r <= res_r[NORM_W-1:0];
            end
            idx_r   <= '0;
            state_r <= E_RD;
          end
        end
        E_RD: state_r <= E_LD;
        E_LD: begin
          out_valid_r <= 1'b1;
          out_sol_r   <= sw_x;
          out_row_r   <= ROW_W'(idx_r);
          out_last_r  <= last_row;
          out_ov_r    <= ov_r;
          state_r     <= E_WT;
        end
        E_WT: begin
          if (out_ch.ready) begin
            out_valid_r <= 1'b0;
            if (out_last_r) begin
              state_r <= S_IDLE;
            end else begin
              idx_r   <= idx_r + AW'(1);
              state_r <= E_RD;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.solution      = out_sol_r;
  assign out_ch.row_index     = out_row_r;
  assign out_ch.last_result   = out_last_r;
  assign out_ch.residual_norm = out_last_r ? out_norm_r : '0;
  assign out_ch.overflow_flag = out_ov_r;

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !out_ch.valid)
    else $error("input open while a result is pending");

  a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.last_result) |-> (CW'(out_ch.row_index) + CW'(1) == n_r))
    else $error("last result not on final row");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_ROWS))
    else $error("row count beyond capacity");

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |=> !div_rsp.done)
    else $error("divider done right after start");

  a_seq_rows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && !out_ch.last_result) |=> ##2
      (out_ch.row_index == $past(out_ch.row_index, 3) + ROW_W'(1)))
    else $error("results out of row order");

endmodule

`default_nettype wire

[sv/tts_div.sv]
// ----------------------------------------------------------------------------
// tts_div
// radix-2 restoring divider, (num << frac) / den, truncated and saturated
// ----------------------------------------------------------------------------
`default_nettype none

module tts_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  tts_pkg::div_req_t req,
  output tts_pkg::div_rsp_t rsp
);
  import tts_pkg::*;

  localparam int DW    = DATA_W + FRAC_BITS;
  localparam int CNT_W = $clog2(DW + 1);
  localparam logic [DW-1:0] POS_LIM = DW'(32'h7FFF_FFFF);
  localparam logic [DW-1:0] NEG_LIM = POS_LIM + DW'(1);

  logic               busy_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [DW-1:0]      dvd_r;
  logic [DATA_W:0]    rem_r;
  logic [DATA_W-1:0]  dmag_r;
  logic               neg_r;
  logic               done_r;
  data_t              quot_r;
  logic               sat_r;

  logic [DATA_W-1:0]  nmag;
  logic [DATA_W-1:0]  dmag;
  logic [DATA_W:0]    rem_sh;
  logic               qbit;
  logic [DATA_W:0]    rem_nxt;

  always_comb begin
    nmag    = req.num[DATA_W-1] ? DATA_W'(-req.num) : DATA_W'(req.num);
    dmag    = req.den[DATA_W-1] ? DATA_W'(-req.den) : DATA_W'(req.den);
    rem_sh  = {rem_r[DATA_W-1:0], dvd_r[DW-1]};
    qbit    = rem_sh >= {1'b0, dmag_r};
    rem_nxt = qbit ? (rem_sh - {1'b0, dmag_r}) : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DW);
        dvd_r  <= {nmag, {FRAC_BITS{1'b0}}};
        rem_r  <= '0;
        dmag_r <= dmag;
        neg_r  <= req.num[DATA_W-1] ^ req.den[DATA_W-1];
      end else if (busy_r) begin
        if (cnt_r != '0) begin
          cnt_r <= cnt_r - CNT_W'(1);
          dvd_r <= {dvd_r[DW-2:0], qbit};
          rem_r <= rem_nxt;
        end else begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          if (!neg_r && dvd_r > POS_LIM) begin
            quot_r <= data_t'(32'h7FFF_FFFF);
            sat_r  <= 1'b1;
          end else if (neg_r && dvd_r > NEG_LIM) begin
            quot_r <= data_t'(32'h8000_0000);
            sat_r  <= 1'b1;
          end else begin
            quot_r <= neg_r ? data_t'(-dvd_r[DATA_W-1:0]) : data_t'(dvd_r[DATA_W-1:0]);
            sat_r  <= 1'b0;
          end
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;
  assign rsp.sat  = sat_r;

endmodule

`default_nettype wire

[dv/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for tridiagonal_thomas_solver_core: rows are sent as
// tridiagonal systems, directed and of random size and content, a fixed-point thomas solver
// inside the bench predicts every solution element and the residual norm,
// and each result is compared field by field under random idling and stalls
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import tts_pkg::*;

  localparam int CAP  = 64;
  localparam int FRAC = 16;

  typedef struct {
    data_t a;
    data_t b;
    data_t c;
    data_t d;
    logic  fin;
    logic  drain;
  } row_req_t;

  typedef struct {
    data_t             x;
    logic [ROW_W-1:0]  idx;
    logic              last;
    logic [NORM_W-1:0] norm;
    logic              ov;
  } sol_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  tts_in_if  in_ch();
  tts_out_if out_ch();

  tridiagonal_thomas_solver_core dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #6 clk = ~clk;

  row_req_t pending_rows[$];
  sol_t     expected_sols[$];

  // predictor state
  data_t sys_a[CAP];
  data_t sys_b[CAP];
  data_t sys_c[CAP];
  data_t sys_d[CAP];
  data_t up_s[CAP];
  data_t rhs_s[CAP];
  data_t x_s[CAP];
  int    held_rows = 0;
  logic  dropped = 1'b0;

  int rows_sent = 0;
  int systems_solved = 0;
  int results_seen = 0;
  int mismatches = 0;
  int overflow_systems = 0;
  bit stim_done = 0;

  function automatic data_t clip(input wide_t v, inout logic ov);
    if (v > 64'sh7FFF_FFFF) begin
      ov = 1'b1;
      return 32'sh7FFF_FFFF;
    end
    if (v < -64'sh8000_0000) begin
      ov = 1'b1;
      return 32'sh8000_0000;
    end
    return data_t'(v);
  endfunction

  function automatic wide_t fx_mul(input data_t p, input data_t q);
    wide_t m;
    m = wide_t'(p) * wide_t'(q);
    return m >>> FRAC;
  endfunction

  function automatic data_t fx_div(input data_t num, input data_t den, inout logic ov);
    wide_t n;
    n = wide_t'(num) * (64'sd1 <<< FRAC);
    return clip(n / wide_t'(den), ov);
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res = '0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // forward sweep, back substitution, residual and norm of the held system, queued as expected results
  task automatic solve_held();
    int n;
    data_t den;
    data_t num;
    logic ov;
    wide_t r;
    logic [63:0] mag;
    logic [63:0] sq;
    logic [63:0] sum;
    logic [63:0] root;
    sol_t s;
    n = held_rows;
    ov = dropped;
    sum = '0;
    for (int i = 0; i < n; i++) begin
      if (i == 0) begin
        den = sys_b[0];
        num = sys_d[0];
      end else begin
        den = clip(wide_t'(sys_b[i]) - fx_mul(sys_a[i], up_s[i-1]), ov);
        num = clip(wide_t'(sys_d[i]) - fx_mul(sys_a[i], rhs_s[i-1]), ov);
      end
      if (den == 0) den = 1;
      up_s[i] = (i + 1 < n) ? fx_div(sys_c[i], den, ov) : '0;
      rhs_s[i] = fx_div(num, den, ov);
    end
    x_s[n-1] = rhs_s[n-1];
    for (int i = n - 2; i >= 0; i--)
      x_s[i] = clip(wide_t'(rhs_s[i]) - fx_mul(up_s[i], x_s[i+1]), ov);
    for (int i = 0; i < n; i++) begin
      r = wide_t'(sys_d[i]) - fx_mul(sys_b[i], x_s[i]);
      if (i > 0) r = r - fx_mul(sys_a[i], x_s[i-1]);
      if (i + 1 < n) r = r - fx_mul(sys_c[i], x_s[i+1]);
      mag = (r < 0) ? 64'(-r) : 64'(r);
      if (mag > 64'hFFFF_FFFF) mag = 64'hFFFF_FFFF;
      sq = mag * mag;
      if (sum > ~64'd0 - sq) sum = ~64'd0;
      else sum = sum + sq;
    end
    root = int_sqrt(sum);
    if (root > 64'h7FFF_FFFF) begin
      ov = 1'b1;
      root = 64'h7FFF_FFFF;
    end
    for (int i = 0; i < n; i++) begin
      s.x = x_s[i];
      s.idx = i[ROW_W-1:0];
      s.last = (i + 1 == n);
      s.norm = s.last ? root[NORM_W-1:0] : '0;
      s.ov = ov;
      expected_sols.push_back(s);
    end
    if (ov) overflow_systems++;
    systems_solved++;
    held_rows = 0;
    dropped = 1'b0;
  endtask

  task automatic take_row(input row_req_t q);
    if (held_rows < CAP) begin
      sys_a[held_rows] = q.a;
      sys_b[held_rows] = q.b;
      sys_c[held_rows] = q.c;
      sys_d[held_rows] = q.d;
      held_rows++;
    end else begin
      dropped = 1'b1;
    end
    if (q.fin) solve_held();
  endtask

  function automatic int idle_mode();
    return (rows_sent / 60) % 4;
  endfunction

  // driver
  row_req_t cur;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        take_row(cur);
        rows_sent++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_rows.size() > 0 &&
            !(pending_rows[0].drain && expected_sols.size() > 0) &&
            !((idle_mode() == 1 && $urandom_range(99) < 64) ||
              (idle_mode() == 3 && $urandom_range(99) < 20))) begin
          cur = pending_rows.pop_front();
          in_ch.valid      <= 1'b1;
          in_ch.sub_diag   <= cur.a;
          in_ch.main_diag  <= cur.b;
          in_ch.super_diag <= cur.c;
          in_ch.right_side <= cur.d;
          in_ch.final_row  <= cur.fin;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor and scoreboard
  always @(posedge clk) begin
    sol_t e;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (expected_sols.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t unexpected result row %0d", $time, out_ch.row_index);
        end else begin
          e = expected_sols.pop_front();
          if (out_ch.solution !== e.x || out_ch.row_index !== e.idx ||
              out_ch.last_result !== e.last || out_ch.residual_norm !== e.norm ||
              out_ch.overflow_flag !== e.ov) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t mismatch exp x=%h row=%0d last=%b norm=%h ov=%b got x=%h row=%0d last=%b norm=%h ov=%b",
                       $time, e.x, e.idx, e.last, e.norm, e.ov, out_ch.solution,
                       out_ch.row_index, out_ch.last_result, out_ch.residual_norm,
                       out_ch.overflow_flag);
          end
        end
      end
      out_ch.ready <= !((idle_mode() == 2 && $urandom_range(99) < 64) ||
                        (idle_mode() == 3 && $urandom_range(99) < 20));
    end
  end

  function automatic void add_row(input data_t a, input data_t b, input data_t c,
                                  input data_t d, input logic fin, input logic drain = 0);
    row_req_t q;
    q.a = a; q.b = b; q.c = c; q.d = d; q.fin = fin; q.drain = drain;
    pending_rows.push_back(q);
  endfunction

  function automatic data_t mild(input int span);
    return data_t'($urandom_range(2 * span) - span);
  endfunction

  // random system: well conditioned most of the time, raw bits otherwise
  function automatic void add_system(input int n);
    bit raw;
    data_t a, c;
    raw = ($urandom_range(99) < 25);
    for (int i = 0; i < n; i++) begin
      if (raw) begin
        add_row($urandom, $urandom, $urandom, $urandom, i == n - 1);
      end else begin
        a = mild(32'h2_0000);
        c = mild(32'h2_0000);
        add_row(a, data_t'(($urandom_range(1) ? 1 : -1) *
                 ($urandom_range(32'h8_0000) + 32'h4_0000)), c,
                mild(32'h40_0000), i == n - 1);
      end
    end
  endfunction

  initial begin
    int sz;
    in_ch.valid = 1'b0;
    in_ch.sub_diag = '0;
    in_ch.main_diag = '0;
    in_ch.super_diag = '0;
    in_ch.right_side = '0;
    in_ch.final_row = 1'b0;
    out_ch.ready = 1'b0;
    // single row
    add_row(0, 32'sh2_0000, 0, 32'sh3_0000, 1);
    // zero first pivot, single row
    add_row(0, 0, 0, 32'sh1_0000, 1);
    // saturating quotient and extreme fields
    add_row(32'sh8000_0000, 32'sh0000_0001, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1);
    add_row(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1);
    add_row(32'shFFFF_FFFF, 32'shFFFF_FFFF, 32'shFFFF_FFFF, 32'sh8000_0000, 1);
    // zero first pivot in a longer system
    add_row(0, 0, 32'sh1_0000, 32'sh1_0000, 0);
    add_row(32'sh1_0000, 32'sh4_0000, 32'sh1_0000, 32'sh2_0000, 0);
    add_row(32'sh1_0000, 32'sh4_0000, 0, 32'shFFFF_0000, 1);
    // zero later pivot
    add_row(0, 32'sh1_0000, 32'sh1_0000, 32'sh1_0000, 0);
    add_row(32'sh1_0000, 32'sh1_0000, 0, 32'sh2_0000, 1, 1);
    // plain system: ones off the diagonal and in the right side, threes on it
    for (int i = 0; i < 4; i++)
      add_row(32'sh1_0000, 32'sh3_0000, 32'sh1_0000, 32'sh1_0000, i == 3);
    // full capacity, then rows beyond it ending in a dropped final row
    for (int i = 0; i < CAP + 3; i++)
      add_row(mild(32'h1_0000), 32'sh5_0000, mild(32'h1_0000), mild(32'h10_0000),
              i == CAP + 2, i == 0);
    while (pending_rows.size() < 396) begin
      case ($urandom_range(19))
        0:       sz = $urandom_range(CAP, 16);
        1:       sz = $urandom_range(CAP + 4, CAP + 1);
        default: sz = $urandom_range(8, 1);
      endcase
      add_system(sz);
      if ($urandom_range(15) == 0) pending_rows[pending_rows.size() - sz].drain = 1'b1;
    end
    stim_done = 1;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    wait (stim_done);
    wait (pending_rows.size() == 0 && !in_ch.valid);
    wait (expected_sols.size() == 0);
    repeat (300) @(posedge clk);
    $display("sent %0d rows in %0d systems, checked %0d results", rows_sent,
             systems_solved, results_seen);
    $display("%0d systems flagged overflow, %0d mismatches", overflow_systems, mismatches);
    if (mismatches == 0 && expected_sols.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

`default_nettype wire
